// ===== hdl/dccd_pkg.sv =====
// shared types, command codes and constants for the display control command decoder
`timescale 1ns / 1ps

package dccd_pkg;

    typedef enum logic [7:0] {
        CMD_RESET     = 8'd0,
        CMD_FLUSH     = 8'd1,
        CMD_IRQ_ACK   = 8'd2,
        CMD_ENABLE    = 8'd3,
        CMD_DMA       = 8'd4,
        CMD_VRAM      = 8'd5,
        CMD_HRANGE    = 8'd6,
        CMD_VRANGE    = 8'd7,
        CMD_MODE      = 8'd8
    } cmd_t;

    typedef enum logic [1:0] {
        FX_NONE    = 2'd0,
        FX_FLUSH   = 2'd1,
        FX_IRQ_ACK = 2'd2,
        FX_RESET   = 2'd3
    } effect_t;

    typedef struct packed {
        logic [7:0]  kind;
        logic [23:0] parameter_req;
    } in_word_t;

    typedef struct packed {
        logic        display_off;
        logic [1:0]  dma_direction;
        logic [9:0]  vram_x;
        logic [8:0]  vram_y;
        logic [11:0] horiz_first;
        logic [11:0] horiz_last;
        logic [9:0]  line_first;
        logic [9:0]  line_last;
        logic [5:0]  mode_bits;
        logic [9:0]  frame_width;
        logic [8:0]  frame_height;
        logic [1:0]  side_effect;
    } out_word_t;

    typedef struct packed {
        logic        display_off;
        logic [1:0]  dma_mode;
        logic [9:0]  start_column;
        logic [8:0]  start_row;
        logic [11:0] horiz_begin;
        logic [11:0] horiz_finish;
        logic [9:0]  line_begin;
        logic [9:0]  line_finish;
        logic [1:0]  hres_low;
        logic        hres_high;
        logic        tall_mode;
        logic        pal_mode;
        logic        deep_colour;
        logic        interlace_on;
    } disp_state_t;

    localparam disp_state_t DISP_RESET = '{
        display_off:  1'b0,
        dma_mode:     2'd0,
        start_column: 10'd0,
        start_row:    9'd0,
        horiz_begin:  12'h200,
        horiz_finish: 12'hC00,
        line_begin:   10'h010,
        line_finish:  10'h100,
        hres_low:     2'd0,
        hres_high:    1'b0,
        tall_mode:    1'b0,
        pal_mode:     1'b0,
        deep_colour:  1'b0,
        interlace_on: 1'b0
    };

    localparam logic [8:0] HEIGHT_TALL  = 9'd480;
    localparam logic [8:0] HEIGHT_SHORT = 9'd240;

    // frame width from the three resolution bits
    function automatic logic [9:0] width_of(input logic [2:0] idx);
        logic [9:0] w;
        case (idx)
            3'd0:    w = 10'd256;
            3'd1:    w = 10'd320;
            3'd2:    w = 10'd512;
            3'd3:    w = 10'd640;
            3'd4:    w = 10'd368;
            default: w = 10'd256;
        endcase
        return w;
    endfunction

endpackage

// ===== hdl/dccd_state.sv =====
// display state registers and command decode
`timescale 1ns / 1ps

module dccd_state
    import dccd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        apply,
    input  in_word_t    cmd_word,
    output disp_state_t state_next,
    output effect_t     effect
);

    disp_state_t state_reg;
    logic [23:0] p;

    assign p = cmd_word.parameter_req;

    always_comb begin
        state_next = state_reg;
        effect     = FX_NONE;
        case (cmd_word.kind)
            CMD_RESET: begin
                state_next = DISP_RESET;
                effect     = FX_RESET;
            end
            CMD_FLUSH: begin
                effect = FX_FLUSH;
            end
            CMD_IRQ_ACK: begin
                effect = FX_IRQ_ACK;
            end
            CMD_ENABLE: begin
                state_next.display_off = p[0];
            end
            CMD_DMA: begin
                state_next.dma_mode = p[1:0];
            end
            CMD_VRAM: begin
                state_next.start_column = {p[9:1], 1'b0};
                state_next.start_row    = p[18:10];
            end
            CMD_HRANGE: begin
                state_next.horiz_begin  = p[11:0];
                state_next.horiz_finish = p[23:12];
            end
            CMD_VRANGE: begin
                state_next.line_begin  = p[9:0];
                state_next.line_finish = p[19:10];
            end
            CMD_MODE: begin
                state_next.hres_low     = p[1:0];
                state_next.tall_mode    = p[2];
                state_next.pal_mode     = p[3];
                state_next.deep_colour  = p[4];
                state_next.interlace_on = p[5];
                state_next.hres_high    = p[6];
            end
            default: begin
                // unknown command, nothing changes
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= DISP_RESET;
        end else if (apply) begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hdl/dccd_format.sv =====
// builds the result word from the updated display state
`timescale 1ns / 1ps

module dccd_format
    import dccd_pkg::*;
(
    input  disp_state_t st,
    input  effect_t     effect,
    output out_word_t   res
);

    always_comb begin
        res.display_off   = st.display_off;
        res.dma_direction = st.dma_mode;
        res.vram_x        = st.start_column;
        res.vram_y        = st.start_row;
        res.horiz_first   = st.horiz_begin;
        res.horiz_last    = st.horiz_finish;
        res.line_first    = st.line_begin;
        res.line_last     = st.line_finish;
        res.mode_bits     = {st.deep_colour, st.pal_mode, st.tall_mode,
                             st.hres_high, st.hres_low};
        res.frame_width   = width_of({st.hres_high, st.hres_low});
        res.frame_height  = (st.interlace_on || st.tall_mode) ? HEIGHT_TALL : HEIGHT_SHORT;
        res.side_effect   = effect;
    end

endmodule

// ===== hdl/display_control_command_decoder_unit.sv =====
// top level of the display control command decoder
`timescale 1ns / 1ps

// display control command decoder
// s_ channel: one command word per handshake (command number plus 24-bit
//   parameter); accepted when s_valid and s_ready are both high
// m_ channel: one result word per command, carrying the display state after the
//   command (interlace bit apart), the derived frame width and height, and a
//   side-effect code (flush, irq ack, full reset pulse)
// a command goes from the input register through decode and format logic into
//   the result register, which drives m_valid
// throughput: one word per cycle unless the receiver stalls; one register write
//   per command updates the state, so back-to-back commands see each other's effects
// when the receiver stalls, the result register holds its word and the input
//   register holds the next one; s_ready drops only when both are full
// reset (aresetn low, synchronous) empties both stages and loads the display
//   registers with their power-on values; a reset command does the same to
//   the display registers and reports side-effect code 3

module display_control_command_decoder_unit
    import dccd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    // input stage
    logic        in_valid_reg;
    logic        in_valid_next;
    in_word_t    in_word_reg;

    // result stage
    logic        out_valid_reg;
    logic        out_valid_next;
    out_word_t   out_word_reg;

    logic        advance;
    disp_state_t state_next;
    effect_t     effect;
    out_word_t   res;

    // move the held command into the result register when there is room
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    dccd_state u_state (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .apply      (advance),
        .cmd_word   (in_word_reg),
        .state_next (state_next),
        .effect     (effect)
    );

    dccd_format u_format (
        .st     (state_next),
        .effect (effect),
        .res    (res)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_word_reg <= s_data;
        end
        if (advance) begin
            out_word_reg <= res;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_word_reg;

endmodule

// ===== test/display_control_command_decoder_unit_tb.sv =====
// self-checking testbench for the display control command decoder
`timescale 1ns / 1ps

module display_control_command_decoder_unit_tb;
    import dccd_pkg::*;

    // command numbers with no decode, used for the unknown-command cases
    localparam logic [7:0] CMD_UNKNOWN_LOW = 8'd9;
    localparam logic [7:0] CMD_UNKNOWN_MID = 8'h80;
    localparam logic [7:0] CMD_UNKNOWN_TOP = 8'hFF;

    localparam int RANDOM_WORDS = 1225;
    localparam int IDLE_PERCENT = 32;
    localparam int MAX_REPORTS  = 10;
    // receiver hold-off window, long enough to back up both pipeline stages
    localparam int HOLD_START   = 400;
    localparam int HOLD_LEN     = 300;
    // stretch where neither side idles
    localparam int CALM_START   = 1200;
    localparam int CALM_END     = 1600;
    // random word before which the sender waits for the pipe to empty
    localparam int DRAIN_AT     = 900;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_word_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_word_t m_data;

    display_control_command_decoder_unit u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // 50 MHz clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // predicted display registers, advanced once per accepted command word
    disp_state_t display_regs;

    // command words waiting to be driven, with a flag asking the sender to
    // wait for every outstanding result before offering that word
    in_word_t    command_queue[$];
    bit          drain_queue[$];
    // predicted result words, oldest first
    out_word_t   status_queue[$];

    int          words_sent      = 0;
    int          results_checked = 0;
    int          mismatch_count  = 0;
    int          input_stalls    = 0;
    int          reset_cmds      = 0;
    int          unknown_cmds    = 0;

    int          run_cycle  = 0;
    int          hold_count = 0;
    logic        calm;

    assign calm = (run_cycle >= CALM_START) && (run_cycle < CALM_END);

    // decode one command word into the predicted registers and build the
    // status word the block should report for it
    function automatic out_word_t decode_command(in_word_t w);
        out_word_t  r;
        logic [23:0] p;
        logic [2:0]  res_index;
        p = w.parameter_req;
        r.side_effect = FX_NONE;
        case (w.kind)
            CMD_RESET: begin
                display_regs = DISP_RESET;
                r.side_effect = FX_RESET;
            end
            CMD_FLUSH:   r.side_effect = FX_FLUSH;
            CMD_IRQ_ACK: r.side_effect = FX_IRQ_ACK;
            CMD_ENABLE:  display_regs.display_off = p[0];
            CMD_DMA:     display_regs.dma_mode = p[1:0];
            CMD_VRAM: begin
                // column bit 0 is dropped so the start stays even
                display_regs.start_column = {p[9:1], 1'b0};
                display_regs.start_row    = p[18:10];
            end
            CMD_HRANGE: begin
                display_regs.horiz_begin  = p[11:0];
                display_regs.horiz_finish = p[23:12];
            end
            CMD_VRANGE: begin
                display_regs.line_begin  = p[9:0];
                display_regs.line_finish = p[19:10];
            end
            CMD_MODE: begin
                display_regs.hres_low     = p[1:0];
                display_regs.tall_mode    = p[2];
                display_regs.pal_mode     = p[3];
                display_regs.deep_colour  = p[4];
                display_regs.interlace_on = p[5];
                display_regs.hres_high    = p[6];
            end
            default: ;
        endcase

        r.display_off   = display_regs.display_off;
        r.dma_direction = display_regs.dma_mode;
        r.vram_x        = display_regs.start_column;
        r.vram_y        = display_regs.start_row;
        r.horiz_first   = display_regs.horiz_begin;
        r.horiz_last    = display_regs.horiz_finish;
        r.line_first    = display_regs.line_begin;
        r.line_last     = display_regs.line_finish;
        // mode bits are repacked: hres high moves below tall, interlace is hidden
        r.mode_bits     = {display_regs.deep_colour, display_regs.pal_mode,
                           display_regs.tall_mode, display_regs.hres_high,
                           display_regs.hres_low};
        res_index = {display_regs.hres_high, display_regs.hres_low};
        case (res_index)
            3'd1:    r.frame_width = 10'd320;
            3'd2:    r.frame_width = 10'd512;
            3'd3:    r.frame_width = 10'd640;
            3'd4:    r.frame_width = 10'd368;
            default: r.frame_width = 10'd256;
        endcase
        r.frame_height = (display_regs.interlace_on || display_regs.tall_mode) ?
                         HEIGHT_TALL : HEIGHT_SHORT;
        return r;
    endfunction

    task automatic queue_command(input logic [7:0] kind, input logic [23:0] param,
                                 input bit drain_first);
        in_word_t w;
        w.kind          = kind;
        w.parameter_req = param;
        command_queue.push_back(w);
        drain_queue.push_back(drain_first);
    endtask

    task automatic compare_field(input string name, input int unsigned exp_v,
                                 input int unsigned act_v);
        if (exp_v != act_v) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("mismatch on result %0d field %s: expected 0x%0h, got 0x%0h",
                         results_checked, name, exp_v, act_v);
        end
    endtask

    // stimulus: directed words first, then weighted random commands
    initial begin
        int        pick;
        logic [7:0]  kind;
        logic [23:0] param;
        display_regs = DISP_RESET;

        // each command but reset, mostly with all parameter bits set, then the unknown range
        queue_command(CMD_FLUSH,       24'hFFFFFF, 1'b0);
        queue_command(CMD_IRQ_ACK,     24'h000000, 1'b0);
        queue_command(CMD_ENABLE,      24'hFFFFFF, 1'b0);
        queue_command(CMD_DMA,         24'hFFFFFF, 1'b0);
        queue_command(CMD_VRAM,        24'hFFFFFF, 1'b0);
        queue_command(CMD_HRANGE,      24'hFFFFFF, 1'b0);
        queue_command(CMD_VRANGE,      24'hFFFFFF, 1'b0);
        queue_command(CMD_MODE,        24'hFFFFFF, 1'b0);
        queue_command(CMD_UNKNOWN_LOW, 24'h000000, 1'b0);
        queue_command(CMD_UNKNOWN_TOP, 24'hFFFFFF, 1'b0);
        // reset command from a fully loaded state, then look at it
        queue_command(CMD_RESET,       24'hFFFFFF, 1'b0);
        queue_command(CMD_UNKNOWN_MID, 24'h5A5A5A, 1'b0);
        // resolution indices 1 to 5, the last one falling back to 256
        queue_command(CMD_MODE,        24'h000001, 1'b0);
        queue_command(CMD_MODE,        24'h000002, 1'b0);
        queue_command(CMD_MODE,        24'h000003, 1'b0);
        queue_command(CMD_MODE,        24'h000040, 1'b0);
        queue_command(CMD_MODE,        24'h000041, 1'b0);
        // interlace alone and tall alone both give the tall height
        queue_command(CMD_MODE,        24'h000020, 1'b0);
        queue_command(CMD_MODE,        24'h000004, 1'b0);
        // only ignored bits set, or none, then a DMA mode of 1
        queue_command(CMD_MODE,        24'hFFFF80, 1'b0);
        queue_command(CMD_VRAM,        24'h000001, 1'b0);
        queue_command(CMD_HRANGE,      24'h000000, 1'b0);
        queue_command(CMD_VRANGE,      24'h000000, 1'b0);
        queue_command(CMD_ENABLE,      24'hFFFFFE, 1'b0);
        queue_command(CMD_DMA,         24'h000001, 1'b0);

        for (int i = 0; i < RANDOM_WORDS; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 3)
                kind = CMD_RESET;
            else if (pick < 11)
                kind = 8'($urandom_range(CMD_UNKNOWN_LOW, CMD_UNKNOWN_TOP));
            else
                kind = 8'($urandom_range(CMD_FLUSH, CMD_MODE));
            pick = $urandom_range(0, 99);
            if (pick < 8)
                param = 24'hFFFFFF;
            else if (pick < 13)
                param = 24'h000000;
            else
                param = 24'($urandom());
            // pause after the directed part and once in the middle
            queue_command(kind, param, (i == 0) || (i == DRAIN_AT));
        end

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // all words handed over, then all results back
        while (command_queue.size() != 0 || s_valid)
            @(posedge aclk);
        while (status_queue.size() != 0)
            @(posedge aclk);
        // two-stage pipe; give it a little extra to catch any stray word
        repeat (16) @(posedge aclk);

        if (status_queue.size() != 0)
            mismatch_count++;
        $display("sent %0d command words (%0d resets, %0d unknown), checked %0d results",
                 words_sent, reset_cmds, unknown_cmds, results_checked);
        $display("input back-pressure seen on %0d cycles, %0d field mismatches",
                 input_stalls, mismatch_count);
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // sender: holds a word until accepted, predicts its result on acceptance
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                if (s_data.kind == CMD_RESET)
                    reset_cmds++;
                if (s_data.kind >= CMD_UNKNOWN_LOW)
                    unknown_cmds++;
                status_queue.push_back(decode_command(s_data));
                words_sent++;
            end
            if (s_valid && !s_ready)
                input_stalls++;
            // free to present a new word or to go idle
            if (!s_valid || s_ready) begin
                if (command_queue.size() == 0) begin
                    s_valid <= 1'b0;
                end else if (drain_queue[0] && status_queue.size() != 0) begin
                    // waiting for the pipe to empty
                    s_valid <= 1'b0;
                end else if (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
                    drain_queue[0] = 1'b0;
                    s_valid <= 1'b0;
                end else begin
                    s_valid <= 1'b1;
                    s_data  <= command_queue.pop_front();
                    void'(drain_queue.pop_front());
                end
            end
        end
    end

    // cycle count and the long receiver hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            run_cycle  <= 0;
            hold_count <= 0;
        end else begin
            run_cycle <= run_cycle + 1;
            if (run_cycle == HOLD_START)
                hold_count <= HOLD_LEN;
            else if (hold_count != 0)
                hold_count <= hold_count - 1;
        end
    end

    // receiver: random stalls, checks each accepted result word
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (status_queue.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("unexpected result word 0x%0h", m_data);
                end else begin
                    out_word_t want;
                    want = status_queue.pop_front();
                    compare_field("display_off",   32'(want.display_off),
                                  32'(m_data.display_off));
                    compare_field("dma_direction", 32'(want.dma_direction),
                                  32'(m_data.dma_direction));
                    compare_field("vram_x",        32'(want.vram_x),
                                  32'(m_data.vram_x));
                    compare_field("vram_y",        32'(want.vram_y),
                                  32'(m_data.vram_y));
                    compare_field("horiz_first",   32'(want.horiz_first),
                                  32'(m_data.horiz_first));
                    compare_field("horiz_last",    32'(want.horiz_last),
                                  32'(m_data.horiz_last));
                    compare_field("line_first",    32'(want.line_first),
                                  32'(m_data.line_first));
                    compare_field("line_last",     32'(want.line_last),
                                  32'(m_data.line_last));
                    compare_field("mode_bits",     32'(want.mode_bits),
                                  32'(m_data.mode_bits));
                    compare_field("frame_width",   32'(want.frame_width),
                                  32'(m_data.frame_width));
                    compare_field("frame_height",  32'(want.frame_height),
                                  32'(m_data.frame_height));
                    compare_field("side_effect",   32'(want.side_effect),
                                  32'(m_data.side_effect));
                    results_checked++;
                end
            end
            if (hold_count != 0)
                m_ready <= 1'b0;
            else
                m_ready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #4_000_000;
        $display("timeout with %0d results outstanding", status_queue.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/dccd_pkg.sv
hdl/dccd_state.sv
hdl/dccd_format.sv
hdl/display_control_command_decoder_unit.sv
test/display_control_command_decoder_unit_tb.sv
